// ===== hdl/text_console_writer_unit_assert.svh =====
// Assertion macros used by the checker file of the console writer.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define TCW_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define TCW_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    // Field widths fixed by the interface.
    localparam int COL_W       = 8;
    localparam int ROW_OUT_W   = 6;
    localparam int OFFSET_W    = 14;
    localparam int CELL_W      = 16;
    localparam int CELL_ADDR_W = 13;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // Command codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_STRIDE  = 2'd2;
    localparam logic [1:0] REG_COLOR   = 2'd3;

    // Register reset values.
    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd25;
    localparam logic [7:0] RST_STRIDE  = 8'd80;
    localparam logic [7:0] RST_COLOR   = 8'd7;

    // Character codes and fill patterns.
    localparam logic [7:0]        CH_NEWLINE = 8'd10;
    localparam logic [7:0]        CH_TAB     = 8'd9;
    localparam logic [7:0]        BLANK_CHAR = 8'h20;
    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0720;
    localparam logic [7:0]        TAB_MASK   = 8'd7;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [7:0]             char_code;
        logic [CELL_ADDR_W-1:0] cell_address;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]     cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [OFFSET_W-1:0]  cursor_offset;
        logic [CELL_W-1:0]    read_data;
    } rsp_t;

    typedef struct packed {
        logic [7:0] columns_used;
        logic [6:0] rows_used;
        logic [7:0] row_stride;
        logic [7:0] text_color;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_REDUCE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/tcw_regs.sv =====
`timescale 1ns / 1ps

module tcw_regs
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic       wr_en;
    logic [1:0] reg_idx;
    cfg_t       cfg_reg;

    // A write completes in the access phase; the port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns_used <= RST_COLUMNS;
            cfg_reg.rows_used    <= RST_ROWS;
            cfg_reg.row_stride   <= RST_STRIDE;
            cfg_reg.text_color   <= RST_COLOR;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_COLUMNS: cfg_reg.columns_used <= pwdata[7:0];
                REG_ROWS:    cfg_reg.rows_used    <= pwdata[6:0];
                REG_STRIDE:  cfg_reg.row_stride   <= pwdata[7:0];
                REG_COLOR:   cfg_reg.text_color   <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb
    begin
        case (reg_idx)
            REG_COLUMNS: prdata = APB_DW'(cfg_reg.columns_used);
            REG_ROWS:    prdata = APB_DW'(cfg_reg.rows_used);
            REG_STRIDE:  prdata = APB_DW'(cfg_reg.row_stride);
            REG_COLOR:   prdata = APB_DW'(cfg_reg.text_color);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/text_console_writer_unit.sv =====
`timescale 1ns / 1ps

// Teletype console writer over a text buffer of 16-bit cells (attribute high,
// character low). Commands arrive on the cmd channel (valid/stall) and each
// produces exactly one response on the rsp channel (valid/stall) carrying the
// cursor after the command and, for a cell read, the cell contents.
// Configuration registers sit on the APB-style port at byte addresses 0, 4, 8, 12.
// Work per command, from its acceptance to the earliest next acceptance, with the
// response register free; the response is loaded in the cycle before that:
//   put character, newline or tab without scrolling: the execute step alone;
//   cell read: a registered memory read, plus an address reduction when the buffer
//   is smaller than the address range and the address lies beyond it;
//   scroll: one cell copy or blank per cycle over rows*stride cells through the
//   single write port of the cell memory;
//   clear: one cell per cycle over rows*stride cells.
// Only one command is in work at a time; a new command is taken while the
// previous response is still waiting in the output register.
// When the receiver stalls, the response register holds its value; a finished
// command then waits until that register frees, and cmd_stall stays high meanwhile.
// Reset clears the cursor to the top left corner and loads the register defaults
// (80 columns, 25 rows, stride 80, color 7). The cell memory is not cleared.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int MAX_STRIDE = 128,
    parameter int MAX_ROWS   = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp_data
);

    localparam int BUF_CELLS = MAX_STRIDE * MAX_ROWS;
    localparam int AW        = $clog2(BUF_CELLS);
    localparam int SW        = $clog2(MAX_STRIDE + 1);
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int YW        = $clog2(MAX_ROWS);
    localparam int PW        = YW + SW;
    localparam int NW        = RW + SW;
    localparam int CW        = AW + 1;
    localparam int EW        = (PW + 1 > OFFSET_W) ? PW + 1 : OFFSET_W;
    localparam int KW        = 2;
    localparam int RED_SH    = CELL_ADDR_W + 1;
    localparam int RED_MUL   = (BUF_CELLS >= (1 << CELL_ADDR_W)) ? 0 :
                               (1 << RED_SH) / BUF_CELLS;

    // Steps of the read address reduction.
    localparam logic [KW-1:0] K_QUOT = 2'd2;
    localparam logic [KW-1:0] K_BACK = 2'd1;
    localparam logic [KW-1:0] K_FIX  = 2'd0;

    cfg_t cfg;

    // Effective geometry.
    logic [SW-1:0] s_eff;
    logic [RW-1:0] r_eff;
    logic [SW-1:0] w_eff;
    logic [7:0]    w_raw;

    // Cursor and command state.
    state_t           state_reg, state_next;
    logic [COL_W-1:0] x_reg;
    logic [YW-1:0]    y_reg;
    logic             scroll_reg;
    logic             wr_reg;
    logic [1:0]       op_reg;
    logic [7:0]       ch_reg;
    logic [COL_W-1:0] xw_reg;
    logic [PW-1:0]    prod_reg;
    logic [CW-1:0]    area_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CELL_ADDR_W-1:0] rem_reg;
    logic [CELL_ADDR_W-1:0] quot_reg;
    logic [KW-1:0]    k_reg;
    logic             pend_valid_reg;
    logic             pend_blank_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;

    // Cursor step computed from the incoming command.
    logic [COL_W-1:0] step_x;
    logic [YW-1:0]    step_y;
    logic             step_scroll;
    logic             step_wr;
    logic [COL_W-1:0] step_xw;
    logic [PW-1:0]    step_prod;
    logic [CW-1:0]    step_area;
    logic [YW:0]      y_inc;
    logic [YW-1:0]    y_dn;
    logic             scroll_dn;
    logic [COL_W-1:0] tab_x;

    // Cell memory.
    logic [CELL_W-1:0] cell_mem [BUF_CELLS];
    logic [CELL_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              cmd_accept;
    logic              rsp_free;
    logic              rsp_load;
    rsp_t              rsp_next;
    logic [CW-1:0]     keep;
    logic [EW-1:0]     put_sum;
    logic [EW-1:0]     ofs_sum;
    logic [31:0]       quot_full;
    logic [31:0]       back_prod;
    logic              red_ge;
    logic              addr_in_buf;
    logic [CELL_W-1:0] blank_word;

    tcw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the configured geometry to what the buffer supports.
    always_comb
    begin
        if (cfg.row_stride == '0)
            s_eff = SW'(1);
        else if (32'(cfg.row_stride) > MAX_STRIDE)
            s_eff = SW'(MAX_STRIDE);
        else
            s_eff = SW'(cfg.row_stride);

        if (cfg.rows_used == '0)
            r_eff = RW'(1);
        else if (32'(cfg.rows_used) > MAX_ROWS)
            r_eff = RW'(MAX_ROWS);
        else
            r_eff = RW'(cfg.rows_used);

        w_raw = (cfg.columns_used == '0) ? 8'd1 : cfg.columns_used;
        if (32'(w_raw) > 32'(s_eff))
            w_eff = s_eff;
        else
            w_eff = SW'(w_raw);
    end

    // Moving down one row, clamped at the last row with a scroll.
    always_comb
    begin
        y_inc = (YW + 1)'(y_reg) + (YW + 1)'(1);
        if (32'(y_inc) >= 32'(r_eff))
        begin
            y_dn      = YW'(r_eff - RW'(1));
            scroll_dn = 1'b1;
        end
        else
        begin
            y_dn      = YW'(y_inc);
            scroll_dn = 1'b0;
        end
    end

    assign tab_x = (x_reg | TAB_MASK) + COL_W'(1);

    // Cursor update for the incoming command.
    always_comb
    begin
        step_x      = x_reg;
        step_y      = y_reg;
        step_scroll = 1'b0;
        step_wr     = 1'b0;
        step_xw     = x_reg;
        if (cmd_data.opcode == OP_PUT)
        begin
            if (cmd_data.char_code == CH_NEWLINE)
            begin
                step_x      = '0;
                step_y      = y_dn;
                step_scroll = scroll_dn;
            end
            else if (cmd_data.char_code == CH_TAB)
            begin
                if (tab_x >= COL_W'(w_eff))
                begin
                    step_x      = '0;
                    step_y      = y_dn;
                    step_scroll = scroll_dn;
                end
                else
                begin
                    step_x = tab_x;
                end
            end
            else
            begin
                // Deferred wrap: a cursor standing at the width wraps first.
                step_wr = 1'b1;
                if (x_reg >= COL_W'(w_eff))
                begin
                    step_xw     = '0;
                    step_y      = y_dn;
                    step_scroll = scroll_dn;
                end
                step_x = step_xw + COL_W'(1);
            end
        end
        step_prod = PW'(step_y) * PW'(s_eff);
        step_area = CW'(NW'(r_eff) * NW'(s_eff));
    end

    assign cmd_stall   = (state_reg != ST_IDLE);
    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign keep        = area_reg - CW'(s_eff);
    assign put_sum     = EW'(prod_reg) + EW'(xw_reg);
    assign ofs_sum     = EW'(prod_reg) + EW'(x_reg);
    assign quot_full   = (32'(rem_reg) * 32'(RED_MUL)) >> RED_SH;
    assign back_prod   = 32'(quot_reg) * 32'(BUF_CELLS);
    assign red_ge      = 32'(rem_reg) >= 32'(BUF_CELLS);
    assign addr_in_buf = 32'(rem_reg) < BUF_CELLS;
    assign blank_word  = {cfg.text_color, BLANK_CHAR};

    // Response built from the cursor after the command.
    always_comb
    begin
        rsp_next.cursor_col    = x_reg;
        rsp_next.cursor_row    = ROW_OUT_W'(y_reg);
        rsp_next.cursor_offset = OFFSET_W'(ofs_sum);
        rsp_next.read_data     = (op_reg == OP_READ) ? mem_q_reg : '0;
    end

    // Sequencer: next state, memory ports and response load.
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        rsp_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (scroll_reg)
                            state_next = ST_SCROLL;
                        else
                        begin
                            mem_we    = wr_reg;
                            mem_waddr = AW'(put_sum);
                            mem_wdata = {cfg.text_color, ch_reg};
                            if (rsp_free)
                            begin
                                rsp_load   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                                state_next = ST_DONE;
                        end
                    end
                    OP_CLEAR:
                        state_next = ST_CLEAR;
                    OP_READ:
                    begin
                        if (addr_in_buf)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(rem_reg);
                            state_next = ST_DONE;
                        end
                        else
                            state_next = ST_REDUCE;
                    end
                    default:
                    begin
                        if (rsp_free)
                        begin
                            rsp_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                            state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCROLL:
            begin
                // Copy pipeline: read one row ahead, write the cell read in the previous cycle.
                mem_we    = pend_valid_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = pend_blank_reg ? blank_word : mem_q_reg;
                if (cnt_reg < keep)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cnt_reg + CW'(s_eff));
                end
                if (cnt_reg == area_reg)
                    state_next = wr_reg ? ST_EXEC : ST_DONE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_reg);
                mem_wdata = CLEAR_CELL;
                if (cnt_reg == area_reg - CW'(1))
                    state_next = ST_DONE;
            end
            ST_REDUCE:
            begin
                if (k_reg == K_FIX)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(rem_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            x_reg          <= '0;
            y_reg          <= '0;
            scroll_reg     <= 1'b0;
            wr_reg         <= 1'b0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_accept)
            begin
                x_reg      <= step_x;
                y_reg      <= step_y;
                scroll_reg <= step_scroll;
                wr_reg     <= step_wr;
                cnt_reg    <= '0;
            end
            if (state_reg == ST_SCROLL)
            begin
                if (cnt_reg != area_reg)
                begin
                    cnt_reg        <= cnt_reg + CW'(1);
                    pend_valid_reg <= 1'b1;
                end
                else
                begin
                    pend_valid_reg <= 1'b0;
                    scroll_reg     <= 1'b0;
                end
            end
            if (state_reg == ST_CLEAR)
                cnt_reg <= cnt_reg + CW'(1);
            if (state_reg == ST_EXEC)
                k_reg <= K_QUOT;
            if (state_reg == ST_REDUCE && k_reg != K_FIX)
                k_reg <= k_reg - KW'(1);
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg    <= cmd_data.opcode;
            ch_reg    <= cmd_data.char_code;
            xw_reg    <= step_xw;
            prod_reg  <= step_prod;
            area_reg  <= step_area;
            rem_reg   <= cmd_data.cell_address;
        end
        if (state_reg == ST_SCROLL && cnt_reg != area_reg)
        begin
            pend_addr_reg  <= AW'(cnt_reg);
            pend_blank_reg <= !(cnt_reg < keep);
        end
        // Out-of-range read address: reciprocal quotient estimate, subtract the
        // multiple back, then one final correction.
        if (state_reg == ST_REDUCE)
        begin
            if (k_reg == K_QUOT)
                quot_reg <= CELL_ADDR_W'(quot_full);
            else if (k_reg == K_BACK)
                rem_reg <= rem_reg - CELL_ADDR_W'(back_prod);
            else if (red_ge)
                rem_reg <= rem_reg - CELL_ADDR_W'(BUF_CELLS);
        end
        if (rsp_load)
            rsp_data_reg <= rsp_next;
    end

    // Cell memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
    end

    // Cell memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_q_reg <= cell_mem[mem_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== hdl/tcw_checker.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_unit_assert.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       cmd_xfer;
    logic       rsp_xfer;

    assign cmd_xfer = cmd_valid && !cmd_stall;
    assign rsp_xfer = rsp_valid && !rsp_stall;

    // Commands accepted whose response has not yet been transferred.
    always_comb
    begin
        pend_next = pend_reg + 2'(cmd_xfer) - 2'(rsp_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // The block works on one command at a time.
    `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_xfer, cmd_stall)

    // A stalled response is held unchanged.
    `TCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp_data))

    // No response without an accepted command behind it.
    `TCW_ASSERT_SAME(a_rsp_has_cmd, clk, rst_n, rsp_valid, pend_reg != 2'd0)

    // At most one response waiting plus one command in work.
    `TCW_ASSERT_SAME(a_pend_bound, clk, rst_n, 1'b1, pend_reg != 2'd3)

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
